/* hdl/wpf_pkg.sv */
package wpf_pkg;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	localparam logic [1:0] TBL_POS = 2'd0;
	localparam logic [1:0] TBL_AIM = 2'd1;
	localparam logic [1:0] TBL_CTL = 2'd2;

	localparam logic [1:0] REG_SPEED   = 2'd0;
	localparam logic [1:0] REG_POS_LEN = 2'd1;
	localparam logic [1:0] REG_AIM_LEN = 2'd2;
	localparam logic [1:0] REG_CTL_LEN = 2'd3;

	localparam logic [15:0] SPEED_RESET = 16'd9830;
	localparam logic [15:0] HALF_UNIT   = 16'd32768;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MOD,
		ST_WRITE,
		ST_SREAD,
		ST_SLOAD,
		ST_TREAD,
		ST_DIFF,
		ST_SCALE,
		ST_SQ,
		ST_NEAR,
		ST_SQRT,
		ST_DIVI,
		ST_DIV,
		ST_HEAD,
		ST_STEP,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [1:0]         table_select;
		logic [7:0]         point_index;
		logic [7:0]         aim_start_index;
		logic [7:0]         control_start_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
	} wpf_req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] aim_x;
		logic signed [31:0] aim_y;
		logic signed [31:0] aim_z;
		logic [7:0]         target_index;
		logic [7:0]         aim_target_index;
		logic [7:0]         control_index;
		logic [1:0]         status;
	} wpf_rsp_t;

endpackage

/* hdl/wpf_if.sv */
interface wpf_req_if;
	import wpf_pkg::*;
	logic     valid;
	logic     ready;
	wpf_req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface wpf_rsp_if;
	import wpf_pkg::*;
	logic     valid;
	logic     ready;
	wpf_rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hdl/waypoint_path_follower.sv */
// Moves a position point and an aim point along their own closed waypoint tables at the
// speed in spd_q, one request at a time, and answers every request with one result
// holding both points, their target indices, the control index and the empty-path flags.
// In each renormalization the leading-bit shift moves one bit a cycle, the square root
// resolves one bit a cycle and the three divider lanes produce one quotient bit a cycle.
// A tick renormalizes at most twice. The waypoint tables are synchronous memories with
// one write port, one read port and a registered read output. A new request is taken
// while the last result still waits in the output register.
module waypoint_path_follower #(
	parameter int MAX_POINTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	wpf_req_if.sink     req,
	wpf_rsp_if.source   rsp
);
	import wpf_pkg::*;

	localparam int IW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam int LW = $clog2(MAX_POINTS + 1);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_POINTS);

	state_t state_q, state_d;

	logic [15:0] spd_q;
	logic [8:0]  plen_q, alen_q, clen_q;

	wpf_req_t in_q;
	logic     out_valid_q;
	wpf_rsp_t out_q;

	logic signed [31:0] vec_q  [2][3];
	logic signed [31:0] head_q [2][3];
	logic [IW-1:0]      tgt_q  [2];
	logic [IW-1:0]      ctl_tgt_q;
	logic pt_q, ctl_q, norm_q;
	logic pt_d, ctl_d, norm_d;

	logic [8:0]    mod_dvd_q, mod_dvd_d;
	logic [LW-1:0] mod_div_q, mod_div_d, mod_rem_q, mod_new;
	logic [3:0]    mod_cnt_q;
	logic [LW:0]   mod_sh;
	logic          mod_go;

	logic [32:0] m_q [3];
	logic [2:0]  sgn_q;
	logic [32:0] mx_q;
	logic        lt_q;

	logic [2:0]  sq_cnt_q;
	logic [30:0] sq_a;
	logic [61:0] sq_prod_q;
	logic [63:0] sum_q;
	logic [31:0] rr_q;

	logic [63:0] x_q, root_q, rbit_q, sq_t;
	logic [31:0] dr_q  [3];
	logic [30:0] quo_q [3];
	logic [4:0]  div_cnt_q;
	logic [31:0] len;

	logic [1:0]  st_cnt_q, st_mi, st_idx;
	logic [46:0] st_prod_q;
	logic        st_neg_q;
	logic [30:0] st_hmag;
	logic signed [31:0] st_h, st_cur, st_sat;
	logic [33:0] st_sum;

	logic [95:0] pos_mem [MAX_POINTS];
	logic [95:0] aim_mem [MAX_POINTS];
	logic [95:0] ctl_mem [MAX_POINTS];
	logic [95:0] pos_rd_q, aim_rd_q, ctl_rd_q, tab_rd, wr_data;
	logic [IW-1:0] rd_addr, wr_addr;

	logic [LW-1:0] np, na, nc, n_pt, nc_div;
	logic [15:0]   radius;
	logic [32:0]   dif_c [3];
	logic [32:0]   mag_c [3];
	logic [32:0]   mx_c;
	logic          lt_c, near, scale_ok, cfg_wr;

	function automatic logic [LW-1:0] eff_len(input logic [8:0] n);
		logic [31:0] t;
		t = (32'(n) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : 32'(n);
		return t[LW-1:0];
	endfunction

	function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx, input logic [LW-1:0] n);
		logic [31:0] nx;
		nx = 32'(idx) + 32'd1;
		return (nx >= 32'(n)) ? '0 : nx[IW-1:0];
	endfunction

	function automatic logic [7:0] idx8(input logic [IW-1:0] v);
		logic [IW+7:0] w;
		w = {8'd0, v};
		return w[7:0];
	endfunction

	assign np     = eff_len(plen_q);
	assign na     = eff_len(alen_q);
	assign nc     = eff_len(clen_q);
	assign nc_div = (nc != '0) ? nc : MAX_LEN;
	assign n_pt   = pt_q ? na : np;
	assign radius = ctl_q ? HALF_UNIT : spd_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_SPEED:   prdata = {16'd0, spd_q};
			REG_POS_LEN: prdata = {23'd0, plen_q};
			REG_AIM_LEN: prdata = {23'd0, alen_q};
			REG_CTL_LEN: prdata = {23'd0, clen_q};
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// table read path
	assign rd_addr = (state_q == ST_SREAD) ? mod_rem_q[IW-1:0] :
	                 (ctl_q ? ctl_tgt_q : tgt_q[pt_q]);
	assign wr_addr = mod_rem_q[IW-1:0];
	assign wr_data = {in_q.coord_z, in_q.coord_y, in_q.coord_x};
	assign tab_rd  = ctl_q ? ctl_rd_q : (pt_q ? aim_rd_q : pos_rd_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && in_q.table_select == TBL_POS) begin
			pos_mem[wr_addr] <= wr_data;
		end
		pos_rd_q <= pos_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && in_q.table_select == TBL_AIM) begin
			aim_mem[wr_addr] <= wr_data;
		end
		aim_rd_q <= aim_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && in_q.table_select == TBL_CTL) begin
			ctl_mem[wr_addr] <= wr_data;
		end
		ctl_rd_q <= ctl_mem[rd_addr];
	end

	// modulo step
	assign mod_sh  = {mod_rem_q, mod_dvd_q[8]};
	assign mod_new = (mod_sh >= {1'b0, mod_div_q}) ? LW'(mod_sh - {1'b0, mod_div_q}) :
	                 mod_sh[LW-1:0];

	// difference to target
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif_c[i] = {tab_rd[32*i+31], tab_rd[32*i +: 32]} -
			           {vec_q[pt_q][i][31], vec_q[pt_q][i]};
			mag_c[i] = dif_c[i][32] ? (~dif_c[i] + 33'd1) : dif_c[i];
		end
		mx_c = mag_c[0];
		if (mag_c[1] > mx_c) begin
			mx_c = mag_c[1];
		end
		if (mag_c[2] > mx_c) begin
			mx_c = mag_c[2];
		end
		lt_c = (mag_c[0] < {17'd0, radius}) && (mag_c[1] < {17'd0, radius}) &&
		       (mag_c[2] < {17'd0, radius});
	end

	always_comb begin
		case (sq_cnt_q)
			3'd0:    sq_a = m_q[0][30:0];
			3'd1:    sq_a = m_q[1][30:0];
			3'd2:    sq_a = m_q[2][30:0];
			3'd3:    sq_a = {15'd0, radius};
			default: sq_a = '0;
		endcase
	end

	assign near     = lt_q && (sum_q < {32'd0, rr_q});
	assign scale_ok = (mx_q[32:31] == 2'b00) && mx_q[30];
	assign sq_t     = root_q + rbit_q;
	assign len      = root_q[31:0];

	// step along heading
	assign st_mi   = (st_cnt_q == 2'd3) ? 2'd0 : st_cnt_q;
	assign st_idx  = st_cnt_q - 2'd1;
	assign st_h    = head_q[pt_q][st_mi];
	assign st_hmag = st_h[31] ? 31'(~st_h + 32'd1) : st_h[30:0];
	assign st_cur  = vec_q[pt_q][st_idx];
	assign st_sum  = {{2{st_cur[31]}}, st_cur} +
	                 (st_neg_q ? (~{17'd0, st_prod_q[46:30]} + 34'd1) :
	                  {17'd0, st_prod_q[46:30]});

	always_comb begin
		if (st_sum[33:31] == 3'b000 || st_sum[33:31] == 3'b111) begin
			st_sat = st_sum[31:0];
		end else if (st_sum[33]) begin
			st_sat = 32'h8000_0000;
		end else begin
			st_sat = 32'h7fff_ffff;
		end
	end

	always_comb begin
		state_d   = state_q;
		mod_go    = 1'b0;
		mod_dvd_d = '0;
		mod_div_d = MAX_LEN;
		pt_d      = pt_q;
		ctl_d     = ctl_q;
		norm_d    = norm_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					norm_d = 1'b0;
					ctl_d  = 1'b0;
					case (req.data.mode)
						MODE_LOAD: begin
							mod_go    = 1'b1;
							mod_dvd_d = {1'b0, req.data.point_index};
							state_d   = ST_MOD;
						end
						MODE_START: begin
							mod_go  = 1'b1;
							state_d = ST_MOD;
							if (np != '0) begin
								pt_d      = 1'b0;
								mod_dvd_d = {1'b0, req.data.point_index};
								mod_div_d = np;
							end else if (na != '0) begin
								pt_d      = 1'b1;
								mod_dvd_d = {1'b0, req.data.aim_start_index};
								mod_div_d = na;
							end else begin
								ctl_d     = 1'b1;
								mod_dvd_d = {1'b0, req.data.control_start_index} + 9'd2;
								mod_div_d = nc_div;
							end
						end
						MODE_TICK: begin
							if (np != '0) begin
								pt_d    = 1'b0;
								ctl_d   = (nc != '0);
								state_d = ST_TREAD;
							end else if (na != '0) begin
								pt_d    = 1'b1;
								state_d = ST_TREAD;
							end else begin
								state_d = ST_DONE;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_MOD: begin
				if (mod_cnt_q == 4'd1) begin
					if (in_q.mode == MODE_LOAD) begin
						state_d = ST_WRITE;
					end else if (ctl_q) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SREAD;
					end
				end
			end
			ST_WRITE: state_d = ST_DONE;
			ST_SREAD: state_d = ST_SLOAD;
			ST_SLOAD: begin
				norm_d  = 1'b1;
				state_d = ST_TREAD;
			end
			ST_TREAD: state_d = ST_DIFF;
			ST_DIFF: begin
				if (norm_q) begin
					state_d = (mx_c == '0) ? ST_HEAD : ST_SCALE;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_SCALE: begin
				if (scale_ok) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (sq_cnt_q == 3'd4) begin
					state_d = norm_q ? ST_SQRT : ST_NEAR;
				end
			end
			ST_NEAR: begin
				if (ctl_q) begin
					ctl_d   = 1'b0;
					pt_d    = 1'b0;
					state_d = ST_TREAD;
				end else if (near) begin
					norm_d  = 1'b1;
					state_d = ST_TREAD;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_SQRT: begin
				if (rbit_q[0]) begin
					state_d = ST_DIVI;
				end
			end
			ST_DIVI: state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == 5'd1) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: state_d = (in_q.mode == MODE_START) ? ST_NEXT : ST_STEP;
			ST_STEP: begin
				if (st_cnt_q == 2'd3) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (in_q.mode == MODE_START) begin
					mod_go  = 1'b1;
					state_d = ST_MOD;
					if (!pt_q && na != '0) begin
						pt_d      = 1'b1;
						mod_dvd_d = {1'b0, in_q.aim_start_index};
						mod_div_d = na;
					end else begin
						ctl_d     = 1'b1;
						mod_dvd_d = {1'b0, in_q.control_start_index} + 9'd2;
						mod_div_d = nc_div;
					end
				end else if (!pt_q && na != '0) begin
					pt_d    = 1'b1;
					ctl_d   = 1'b0;
					norm_d  = 1'b0;
					state_d = ST_TREAD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			spd_q       <= SPEED_RESET;
			plen_q      <= '0;
			alen_q      <= '0;
			clen_q      <= '0;
			pt_q        <= 1'b0;
			ctl_q       <= 1'b0;
			norm_q      <= 1'b0;
			ctl_tgt_q   <= IW'(1);
			for (int p = 0; p < 2; p++) begin
				tgt_q[p] <= IW'(1);
				for (int i = 0; i < 3; i++) begin
					vec_q[p][i]  <= '0;
					head_q[p][i] <= '0;
				end
			end
		end else begin
			state_q <= state_d;
			pt_q    <= pt_d;
			ctl_q   <= ctl_d;
			norm_q  <= norm_d;
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_SPEED:   spd_q  <= pwdata[15:0];
					REG_POS_LEN: plen_q <= pwdata[8:0];
					REG_AIM_LEN: alen_q <= pwdata[8:0];
					REG_CTL_LEN: clen_q <= pwdata[8:0];
				endcase
			end
			if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_MOD: begin
					if (mod_cnt_q == 4'd1 && in_q.mode != MODE_LOAD && ctl_q) begin
						ctl_tgt_q <= mod_new[IW-1:0];
					end
				end
				ST_SLOAD: begin
					for (int i = 0; i < 3; i++) begin
						vec_q[pt_q][i] <= tab_rd[32*i +: 32];
					end
					tgt_q[pt_q] <= advance(mod_rem_q[IW-1:0], n_pt);
				end
				ST_NEAR: begin
					if (near) begin
						if (ctl_q) begin
							ctl_tgt_q <= advance(ctl_tgt_q, nc);
						end else begin
							tgt_q[pt_q] <= advance(tgt_q[pt_q], n_pt);
						end
					end
				end
				ST_HEAD: begin
					for (int i = 0; i < 3; i++) begin
						head_q[pt_q][i] <= sgn_q[i] ? (~{1'b0, quo_q[i]} + 32'd1) :
						                   {1'b0, quo_q[i]};
					end
				end
				ST_STEP: begin
					if (st_cnt_q != 2'd0) begin
						vec_q[pt_q][st_idx] <= st_sat;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			in_q <= req.data;
		end
		if (mod_go) begin
			mod_dvd_q <= mod_dvd_d;
			mod_div_q <= mod_div_d;
			mod_rem_q <= '0;
			mod_cnt_q <= 4'd9;
		end else if (state_q == ST_MOD) begin
			mod_rem_q <= mod_new;
			mod_dvd_q <= {mod_dvd_q[7:0], 1'b0};
			mod_cnt_q <= mod_cnt_q - 4'd1;
		end
		case (state_q)
			ST_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= mag_c[i];
					sgn_q[i] <= dif_c[i][32];
					quo_q[i] <= '0;
				end
				mx_q     <= mx_c;
				lt_q     <= lt_c;
				sq_cnt_q <= '0;
			end
			ST_SCALE: begin
				sq_cnt_q <= '0;
				if (mx_q[32:31] != 2'b00) begin
					mx_q <= mx_q >> 1;
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= m_q[i] >> 1;
					end
				end else if (!mx_q[30]) begin
					mx_q <= mx_q << 1;
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= m_q[i] << 1;
					end
				end
			end
			ST_SQ: begin
				sq_prod_q <= sq_a * sq_a;
				sq_cnt_q  <= sq_cnt_q + 3'd1;
				if (sq_cnt_q == 3'd0) begin
					sum_q <= '0;
				end else if (sq_cnt_q != 3'd4) begin
					sum_q <= sum_q + {2'b00, sq_prod_q};
				end else begin
					rr_q   <= sq_prod_q[31:0];
					x_q    <= sum_q;
					root_q <= '0;
					rbit_q <= 64'h4000_0000_0000_0000;
				end
			end
			ST_NEAR: st_cnt_q <= '0;
			ST_SQRT: begin
				if (x_q >= sq_t) begin
					x_q    <= x_q - sq_t;
					root_q <= (root_q >> 1) + rbit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				rbit_q <= rbit_q >> 2;
			end
			ST_DIVI: begin
				for (int i = 0; i < 3; i++) begin
					if (m_q[i] >= {1'b0, len}) begin
						dr_q[i]  <= 32'(m_q[i] - {1'b0, len});
						quo_q[i] <= 31'd1;
					end else begin
						dr_q[i]  <= m_q[i][31:0];
						quo_q[i] <= '0;
					end
				end
				div_cnt_q <= 5'd30;
			end
			ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if ({dr_q[i], 1'b0} >= {1'b0, len}) begin
						dr_q[i]  <= 32'({dr_q[i], 1'b0} - {1'b0, len});
						quo_q[i] <= {quo_q[i][29:0], 1'b1};
					end else begin
						dr_q[i]  <= {dr_q[i][30:0], 1'b0};
						quo_q[i] <= {quo_q[i][29:0], 1'b0};
					end
				end
				div_cnt_q <= div_cnt_q - 5'd1;
			end
			ST_HEAD: st_cnt_q <= '0;
			ST_STEP: begin
				st_prod_q <= 47'(st_hmag) * 47'(spd_q);
				st_neg_q  <= st_h[31];
				st_cnt_q  <= st_cnt_q + 2'd1;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_q.pos_x            <= vec_q[0][0];
					out_q.pos_y            <= vec_q[0][1];
					out_q.pos_z            <= vec_q[0][2];
					out_q.aim_x            <= vec_q[1][0];
					out_q.aim_y            <= vec_q[1][1];
					out_q.aim_z            <= vec_q[1][2];
					out_q.target_index     <= idx8(tgt_q[0]);
					out_q.aim_target_index <= idx8(tgt_q[1]);
					out_q.control_index    <= idx8(ctl_tgt_q);
					out_q.status           <= {na == '0, np == '0};
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while busy");

	a_scaled_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ && norm_q) |-> (mx_q[32:31] == 2'b00 && mx_q[30]))
		else $error("difference not scaled into range");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVI) |-> (root_q[63:32] == '0 && root_q[31:30] != 2'b00))
		else $error("root out of range");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HEAD) |-> ((!quo_q[0][30] || quo_q[0][29:0] == '0) &&
		(!quo_q[1][30] || quo_q[1][29:0] == '0) && (!quo_q[2][30] || quo_q[2][29:0] == '0)))
		else $error("heading component above one");
`endif

endmodule
